### rtl/rmj_pkg.sv
`default_nettype none
package rmj_pkg;

  localparam int unsigned FRAC_BITS_DEFAULT   = 16;
  localparam int unsigned QUEUE_DEPTH_DEFAULT = 4;
  localparam int unsigned VAL_W   = 32;
  localparam int unsigned QUO_W   = 32;
  localparam int unsigned SQ_W    = 64;
  localparam int unsigned SR_W    = 96;
  localparam int unsigned RANGE_W = 16;

  localparam logic [RANGE_W-1:0] MIN_RANGE_RESET = 16'd7;
  localparam logic [VAL_W-1:0]   SAT_POS = 32'h7fff_ffff;
  localparam logic [VAL_W-1:0]   SAT_NEG = 32'h8000_0000;

  typedef logic [RANGE_W-1:0] min_range_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] pos_x;
    logic signed [VAL_W-1:0] pos_y;
    logic signed [VAL_W-1:0] vel_x;
    logic signed [VAL_W-1:0] vel_y;
  } item_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] range_dx;
    logic signed [VAL_W-1:0] range_dy;
    logic signed [VAL_W-1:0] bearing_dx;
    logic signed [VAL_W-1:0] bearing_dy;
    logic signed [VAL_W-1:0] rate_dx;
    logic signed [VAL_W-1:0] rate_dy;
    logic                    too_close;
  } result_t;

  // classified item passed from front to back
  typedef struct packed {
    item_t            raw;
    logic [VAL_W-1:0] apx;
    logic [VAL_W-1:0] apy;
  } q_item_t;

endpackage
`default_nettype wire

### rtl/rmj_front.sv
`default_nettype none
module rmj_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             full,
  input  rmj_pkg::item_t   item,
  output logic             q_push,
  input  logic             q_ready,
  output rmj_pkg::q_item_t q_data
);
  import rmj_pkg::*;

  logic    valid;
  q_item_t data;
  logic    take;

  assign full   = valid && !q_ready;
  assign take   = push && !full;
  assign q_push = valid;
  assign q_data = data;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (take) begin
      valid <= 1'b1;
    end else if (q_ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      data.raw <= item;
      data.apx <= item.pos_x[VAL_W-1] ? VAL_W'(-item.pos_x) : VAL_W'(item.pos_x);
      data.apy <= item.pos_y[VAL_W-1] ? VAL_W'(-item.pos_y) : VAL_W'(item.pos_y);
    end
  end

endmodule
`default_nettype wire

### rtl/rmj_queue.sv
`default_nettype none
module rmj_queue #(
  parameter int unsigned DEPTH = rmj_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr,
  output logic             ready,
  input  rmj_pkg::q_item_t wr_data,
  output logic             valid,
  input  logic             rd,
  output rmj_pkg::q_item_t rd_data
);
  import rmj_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  q_item_t          mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_wr;
  logic             do_rd;

  assign ready   = count != CNT_W'(DEPTH);
  assign valid   = count != '0;
  assign do_wr   = wr && ready;
  assign do_rd   = rd && valid;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH)) else $error("queue count above depth");

  a_count_track: assert property (@(posedge clk) disable iff (rst)
    do_rd && !do_wr |=> count == $past(count) - 1'b1) else $error("queue count lost a read");

  a_write_kept: assert property (@(posedge clk) disable iff (rst)
    do_wr && !do_rd |=> valid) else $error("queue empty after write");

endmodule
`default_nettype wire

### rtl/rmj_div.sv
`default_nettype none
module rmj_div #(
  parameter int unsigned NUM_W = 48,
  parameter int unsigned DEN_W = 32
) (
  input  logic                       clk,
  input  logic                       en,
  input  logic [NUM_W-1:0]           num,
  input  logic [DEN_W-1:0]           den,
  input  logic                       neg,
  output logic [rmj_pkg::VAL_W-1:0]  res
);
  import rmj_pkg::*;

  localparam int unsigned REM_W = DEN_W + QUO_W;
  localparam int unsigned CMP_W = (NUM_W > REM_W) ? NUM_W : REM_W;

  logic [REM_W-1:0] rem_q [QUO_W+1];
  logic [DEN_W-1:0] den_q [QUO_W+1];
  logic [QUO_W-1:0] quo_q [QUO_W+1];
  logic             sat_q [QUO_W+1];
  logic             neg_q [QUO_W+1];

  logic [CMP_W-1:0] num_ext;
  logic [CMP_W-1:0] den_top;
  logic [QUO_W-1:0] q_fin;
  logic [QUO_W-1:0] mag;

  assign num_ext = CMP_W'(num);
  assign den_top = CMP_W'(den) << QUO_W;

  always_ff @(posedge clk) begin
    if (en) begin
      sat_q[0] <= num_ext >= den_top;
      rem_q[0] <= num_ext[REM_W-1:0];
      den_q[0] <= den;
      quo_q[0] <= '0;
      neg_q[0] <= neg;
    end
  end

  for (genvar k = 1; k <= QUO_W; k++) begin : g_step
    logic [REM_W-1:0] trial;
    logic             ge;
    assign trial = REM_W'(den_q[k-1]) << (QUO_W - k);
    assign ge    = rem_q[k-1] >= trial;
    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[k] <= ge ? rem_q[k-1] - trial : rem_q[k-1];
        quo_q[k] <= {quo_q[k-1][QUO_W-2:0], ge};
        den_q[k] <= den_q[k-1];
        sat_q[k] <= sat_q[k-1];
        neg_q[k] <= neg_q[k-1];
      end
    end
  end

  // truncated quotient, saturated to the signed output range
  always_comb begin
    q_fin = quo_q[QUO_W];
    mag   = (sat_q[QUO_W] || q_fin > SAT_NEG) ? SAT_NEG : q_fin;
    if (neg_q[QUO_W]) begin
      res = -mag;
    end else begin
      res = (sat_q[QUO_W] || q_fin[QUO_W-1]) ? SAT_POS : q_fin;
    end
  end

endmodule
`default_nettype wire

### rtl/rmj_back.sv
`default_nettype none
module rmj_back #(
  parameter int unsigned FRAC_BITS = rmj_pkg::FRAC_BITS_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 q_valid,
  output logic                 q_pop,
  input  rmj_pkg::q_item_t     q_data,
  input  rmj_pkg::min_range_t  min_range,
  output logic                 empty,
  input  logic                 pop,
  output rmj_pkg::result_t     result
);
  import rmj_pkg::*;

  localparam int unsigned SQ_STAGES = VAL_W;
  localparam int unsigned N0_W = VAL_W + FRAC_BITS;
  localparam int unsigned N2_W = VAL_W + 2 * FRAC_BITS;
  localparam int unsigned N4_W = SR_W + FRAC_BITS;
  localparam int unsigned HALF = SQ_W / 2;

  typedef struct packed {
    logic [SQ_W-1:0]  s;
    logic [VAL_W+1:0] rem;
    logic [VAL_W-1:0] root;
    logic [SQ_W-1:0]  cmag;
    logic             cneg;
    logic [VAL_W-1:0] apx;
    logic [VAL_W-1:0] apy;
    logic             sx;
    logic             sy;
  } sq_t;

  typedef struct packed {
    logic [VAL_W+1:0] rem;
    logic [VAL_W-1:0] root;
  } sq_pair_t;

  function automatic sq_pair_t sqrt_step(logic [VAL_W+1:0] rem, logic [VAL_W-1:0] root,
                                         logic [1:0] bits);
    logic [VAL_W+2:0] cur;
    logic [VAL_W+2:0] trial;
    sq_pair_t         o;
    cur   = {rem[VAL_W:0], bits};
    trial = {1'b0, root, 2'b01};
    if (cur >= trial) begin
      o.rem  = (VAL_W + 2)'(cur - trial);
      o.root = {root[VAL_W-2:0], 1'b1};
    end else begin
      o.rem  = cur[VAL_W+1:0];
      o.root = {root[VAL_W-2:0], 1'b0};
    end
    return o;
  endfunction

  logic en;

  // products
  logic                    v1;
  logic [SQ_W-1:0]         sqx1, sqy1;
  logic signed [SQ_W-1:0]  a1, b1;
  logic [VAL_W-1:0]        apx1, apy1;
  logic                    sx1, sy1;

  // sums
  logic                    v2;
  logic [SQ_W-1:0]         s2;
  logic signed [SQ_W:0]    d2;
  logic [VAL_W-1:0]        apx2, apy2;
  logic                    sx2, sy2;
  logic [SQ_W:0]           d2_neg;

  // square root
  logic                    sq_v [SQ_STAGES];
  sq_t                     sq_q [SQ_STAGES];
  sq_t                     sq_adv [SQ_STAGES];

  // partial products
  logic                    v3, tc3;
  sq_t                     p3;
  logic [SQ_W-1:0]         slo_r, shi_r, ylo, yhi, xlo, xhi;

  // full products
  logic                    v4, tc4;
  logic [VAL_W-1:0]        apx4, apy4, r4;
  logic [SQ_W-1:0]         s4;
  logic [SR_W-1:0]         sr4, pyc4, pxc4;
  logic                    sx4, sy4, cneg4;

  // divider side line
  logic                    dv [QUO_W+1];
  logic                    dtc [QUO_W+1];
  logic [VAL_W-1:0]        e0, e1, e2, e3, e4, e5;

  logic                    out_v;
  result_t                 out_data;
  sq_t                     sq_first;
  sq_pair_t                step0;
  logic [VAL_W-1:0]        r_fin;

  assign en     = !out_v || pop;
  assign q_pop  = en && q_valid;
  assign empty  = !out_v;
  assign result = out_data;
  assign d2_neg = -d2;
  assign step0  = sqrt_step('0, '0, s2[SQ_W-1 -: 2]);
  assign r_fin  = sq_q[SQ_STAGES-1].root;

  always_comb begin
    sq_first.s    = s2;
    sq_first.rem  = step0.rem;
    sq_first.root = step0.root;
    sq_first.cneg = d2[SQ_W];
    sq_first.cmag = d2[SQ_W] ? d2_neg[SQ_W-1:0] : d2[SQ_W-1:0];
    sq_first.apx  = apx2;
    sq_first.apy  = apy2;
    sq_first.sx   = sx2;
    sq_first.sy   = sy2;
  end

  always_comb begin
    sq_adv[0] = sq_first;
    for (int k = 1; k < SQ_STAGES; k++) begin
      sq_adv[k] = sq_q[k-1];
      {sq_adv[k].rem, sq_adv[k].root} = sqrt_step(sq_q[k-1].rem, sq_q[k-1].root,
                                                  sq_q[k-1].s[2*(SQ_STAGES-1-k) +: 2]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1    <= 1'b0;
      v2    <= 1'b0;
      v3    <= 1'b0;
      v4    <= 1'b0;
      out_v <= 1'b0;
      for (int k = 0; k < SQ_STAGES; k++) begin
        sq_v[k] <= 1'b0;
      end
      for (int k = 0; k <= QUO_W; k++) begin
        dv[k] <= 1'b0;
      end
    end else if (en) begin
      v1       <= q_valid;
      v2       <= v1;
      sq_v[0]  <= v2;
      for (int k = 1; k < SQ_STAGES; k++) begin
        sq_v[k] <= sq_v[k-1];
      end
      v3       <= sq_v[SQ_STAGES-1];
      v4       <= v3;
      dv[0]    <= v4;
      for (int k = 1; k <= QUO_W; k++) begin
        dv[k] <= dv[k-1];
      end
      out_v    <= dv[QUO_W];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sqx1 <= q_data.apx * q_data.apx;
      sqy1 <= q_data.apy * q_data.apy;
      a1   <= q_data.raw.vel_x * q_data.raw.pos_y;
      b1   <= q_data.raw.vel_y * q_data.raw.pos_x;
      apx1 <= q_data.apx;
      apy1 <= q_data.apy;
      sx1  <= q_data.raw.pos_x[VAL_W-1];
      sy1  <= q_data.raw.pos_y[VAL_W-1];

      s2   <= sqx1 + sqy1;
      d2   <= (SQ_W + 1)'(a1) - (SQ_W + 1)'(b1);
      apx2 <= apx1;
      apy2 <= apy1;
      sx2  <= sx1;
      sy2  <= sy1;

      for (int k = 0; k < SQ_STAGES; k++) begin
        sq_q[k] <= sq_adv[k];
      end

      p3    <= sq_q[SQ_STAGES-1];
      tc3   <= (r_fin == '0) || (r_fin < VAL_W'(min_range));
      slo_r <= sq_q[SQ_STAGES-1].s[HALF-1:0] * r_fin;
      shi_r <= sq_q[SQ_STAGES-1].s[SQ_W-1:HALF] * r_fin;
      ylo   <= sq_q[SQ_STAGES-1].apy * sq_q[SQ_STAGES-1].cmag[HALF-1:0];
      yhi   <= sq_q[SQ_STAGES-1].apy * sq_q[SQ_STAGES-1].cmag[SQ_W-1:HALF];
      xlo   <= sq_q[SQ_STAGES-1].apx * sq_q[SQ_STAGES-1].cmag[HALF-1:0];
      xhi   <= sq_q[SQ_STAGES-1].apx * sq_q[SQ_STAGES-1].cmag[SQ_W-1:HALF];

      tc4   <= tc3;
      apx4  <= p3.apx;
      apy4  <= p3.apy;
      r4    <= p3.root;
      s4    <= p3.s;
      sx4   <= p3.sx;
      sy4   <= p3.sy;
      cneg4 <= p3.cneg;
      sr4   <= {shi_r, {HALF{1'b0}}} + SR_W'(slo_r);
      pyc4  <= {yhi, {HALF{1'b0}}} + SR_W'(ylo);
      pxc4  <= {xhi, {HALF{1'b0}}} + SR_W'(xlo);

      dtc[0] <= tc4;
      for (int k = 1; k <= QUO_W; k++) begin
        dtc[k] <= dtc[k-1];
      end

      out_data.too_close  <= dtc[QUO_W];
      out_data.range_dx   <= dtc[QUO_W] ? '0 : e0;
      out_data.range_dy   <= dtc[QUO_W] ? '0 : e1;
      out_data.bearing_dx <= dtc[QUO_W] ? '0 : e2;
      out_data.bearing_dy <= dtc[QUO_W] ? '0 : e3;
      out_data.rate_dx    <= dtc[QUO_W] ? '0 : e4;
      out_data.rate_dy    <= dtc[QUO_W] ? '0 : e5;
    end
  end

  rmj_div #(.NUM_W(N0_W), .DEN_W(VAL_W)) u_div_rx (
    .clk(clk), .en(en), .num(N0_W'(apx4) << FRAC_BITS), .den(r4), .neg(sx4), .res(e0)
  );

  rmj_div #(.NUM_W(N0_W), .DEN_W(VAL_W)) u_div_ry (
    .clk(clk), .en(en), .num(N0_W'(apy4) << FRAC_BITS), .den(r4), .neg(sy4), .res(e1)
  );

  rmj_div #(.NUM_W(N2_W), .DEN_W(SQ_W)) u_div_bx (
    .clk(clk), .en(en), .num(N2_W'(apy4) << (2 * FRAC_BITS)), .den(s4), .neg(!sy4),
    .res(e2)
  );

  rmj_div #(.NUM_W(N2_W), .DEN_W(SQ_W)) u_div_by (
    .clk(clk), .en(en), .num(N2_W'(apx4) << (2 * FRAC_BITS)), .den(s4), .neg(sx4),
    .res(e3)
  );

  rmj_div #(.NUM_W(N4_W), .DEN_W(SR_W)) u_div_vx (
    .clk(clk), .en(en), .num(N4_W'(pyc4) << FRAC_BITS), .den(sr4), .neg(sy4 != cneg4),
    .res(e4)
  );

  rmj_div #(.NUM_W(N4_W), .DEN_W(SR_W)) u_div_vy (
    .clk(clk), .en(en), .num(N4_W'(pxc4) << FRAC_BITS), .den(sr4), .neg(sx4 != !cneg4),
    .res(e5)
  );

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_v && !pop |=> out_v && $stable(out_data)) else $error("result dropped while stalled");

  a_stall_freeze: assert property (@(posedge clk) disable iff (rst)
    !en |=> v4 == $past(v4) && dv[QUO_W] == $past(dv[QUO_W])) else $error("pipeline moved on stall");

  a_no_pop_stall: assert property (@(posedge clk) disable iff (rst)
    !en |-> !q_pop) else $error("queue read during stall");

endmodule
`default_nettype wire

### rtl/radar_measurement_jacobian.sv
// throughput: one transaction per cycle unless the back pipeline is stalled;
// square root and six dividers are fully pipelined
// a full output register stalls the back pipeline; the front keeps filling the queue
// reset: synchronous, clears all valid bits and the queue, min_range returns to 7
`default_nettype none
module radar_measurement_jacobian #(
  parameter int unsigned FRAC_BITS   = rmj_pkg::FRAC_BITS_DEFAULT,
  parameter int unsigned QUEUE_DEPTH = rmj_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  rmj_pkg::item_t      item,
  output logic                empty,
  input  logic                pop,
  output rmj_pkg::result_t    result,
  input  logic                cfg_wr,
  input  rmj_pkg::min_range_t cfg_data
);
  import rmj_pkg::*;

  min_range_t min_range;
  logic       f_push;
  logic       q_ready;
  q_item_t    f_data;
  logic       q_valid;
  logic       q_pop;
  q_item_t    q_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_range <= MIN_RANGE_RESET;
    end else if (cfg_wr) begin
      min_range <= cfg_data;
    end
  end

  rmj_front u_front (
    .clk(clk), .rst(rst), .push(push), .full(full), .item(item),
    .q_push(f_push), .q_ready(q_ready), .q_data(f_data)
  );

  rmj_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk(clk), .rst(rst), .wr(f_push), .ready(q_ready), .wr_data(f_data),
    .valid(q_valid), .rd(q_pop), .rd_data(q_data)
  );

  rmj_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk(clk), .rst(rst), .q_valid(q_valid), .q_pop(q_pop), .q_data(q_data),
    .min_range(min_range), .empty(empty), .pop(pop), .result(result)
  );

  a_close_zero: assert property (@(posedge clk) disable iff (rst)
    !empty && result.too_close |-> result.range_dx == '0 && result.range_dy == '0 &&
      result.bearing_dx == '0 && result.bearing_dy == '0 &&
      result.rate_dx == '0 && result.rate_dy == '0) else $error("too_close with nonzero entry");

endmodule
`default_nettype wire

### tb/sv/tb.sv
`default_nettype none
module tb;
  import rmj_pkg::*;

  localparam int FRAC = 16;
  localparam int LATENCY = 72;
  localparam longint CYCLE_LIMIT = 400000;

  typedef struct {
    logic [31:0] px, py, vx, vy;
    logic        chk;
    logic        tc;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic pop = 1'b0;
  logic cfg_wr = 1'b0;
  min_range_t cfg_data = '0;
  item_t item = '0;
  logic full, empty;
  result_t result;

  radar_measurement_jacobian u_top (
    .clk(clk), .rst(rst), .push(push), .full(full), .item(item),
    .empty(empty), .pop(pop), .result(result), .cfg_wr(cfg_wr), .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  result_t jacobian_q[$];
  int errors = 0;
  longint cycles = 0;
  logic [15:0] min_range = 16'd7;
  bit hold_pop = 1'b0;
  bit no_idle = 1'b0;
  int hold_cycles = 0;

  function automatic logic signed [31:0] sat_div(bit neg, logic [191:0] num, logic [191:0] den);
    logic [191:0] q;
    q = num / den;
    if (neg) begin
      if (q > 192'h8000_0000) q = 192'h8000_0000;
      return 32'(-q);
    end
    if (q > 192'h7fff_ffff) q = 192'h7fff_ffff;
    return 32'(q);
  endfunction

  function automatic logic [63:0] int_sqrt(logic [63:0] s);
    logic [63:0] res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > s) b = b >> 2;
    while (b != 0) begin
      if (s >= res + b) begin
        s = s - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic result_t jacobian(item_t it);
    result_t o;
    logic signed [63:0] px, py, vx, vy, a, b;
    logic [63:0] apx, apy, s, r, cmag;
    bit cneg, nx, ny;
    px = it.pos_x; py = it.pos_y; vx = it.vel_x; vy = it.vel_y;
    nx = px < 0; ny = py < 0;
    apx = nx ? -px : px;
    apy = ny ? -py : py;
    s = apx * apx + apy * apy;
    r = int_sqrt(s);
    o = '0;
    if (r == 0 || r < {48'd0, min_range}) begin
      o.too_close = 1'b1;
      return o;
    end
    a = vx * py;
    b = vy * px;
    cneg = a < b;
    cmag = cneg ? b - a : a - b;
    o.range_dx   = sat_div(nx, 192'(apx) << FRAC, 192'(r));
    o.range_dy   = sat_div(ny, 192'(apy) << FRAC, 192'(r));
    o.bearing_dx = sat_div(!ny, 192'(apy) << (2 * FRAC), 192'(s));
    o.bearing_dy = sat_div(nx, 192'(apx) << (2 * FRAC), 192'(s));
    o.rate_dx = sat_div(ny != cneg, (192'(apy) * 192'(cmag)) << FRAC, 192'(s) * 192'(r));
    o.rate_dy = sat_div(nx != !cneg, (192'(apx) * 192'(cmag)) << FRAC, 192'(s) * 192'(r));
    return o;
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t timeout", $time);
      $display("DONE: errors detected");
      $finish;
    end
  end

  // result side
  always @(posedge clk) begin
    result_t exp_r;
    if (!rst && pop && !empty) begin
      if (jacobian_q.size() == 0) begin
        errors++;
        $display("%0t unexpected transaction %h", $time, result);
      end else begin
        exp_r = jacobian_q.pop_front();
        if (result !== exp_r) begin
          errors++;
          $display("%0t mismatch expected %h actual %h", $time, exp_r, result);
        end
      end
    end
  end

  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      pop <= 1'b0;
    end else if (hold_pop) begin
      hold_cycles <= 600;
      pop <= 1'b0;
    end else begin
      pop <= no_idle ? 1'b1 : ($urandom_range(99) >= 6);
    end
  end

  task automatic send(item_t it);
    while ($urandom_range(99) < 6 && !no_idle) begin
      push <= 1'b0;
      @(negedge clk);
    end
    item <= it;
    push <= 1'b1;
    @(posedge clk);
    while (full) @(posedge clk);
    jacobian_q.push_back(jacobian(it));
    @(negedge clk);
  endtask

  task automatic drain;
    push <= 1'b0;
    while (jacobian_q.size() != 0) @(negedge clk);
    repeat (LATENCY + 8) @(negedge clk);
  endtask

  task automatic set_min_range(logic [15:0] v);
    drain();
    cfg_data <= v;
    cfg_wr <= 1'b1;
    @(negedge clk);
    cfg_wr <= 1'b0;
    min_range = v;
  endtask

  function automatic logic [31:0] rand_val(int sel);
    case (sel)
      0: return $urandom();
      1: return 32'($signed($urandom_range(2000)) - 1000) <<< 16;
      2: return 32'($signed($urandom_range(4000)) - 2000);
      3: return 32'($signed($urandom_range(60)) - 30);
      default: return 32'($signed($urandom_range(200000)) - 100000) <<< 8;
    endcase
  endfunction

  stim_row_t rows[] = '{
    '{32'h0, 32'h0, 32'h0, 32'h0, 1'b1, 1'b1},
    '{32'h1, 32'h1, 32'h1, 32'h1, 1'b1, 1'b1},
    '{32'h6, 32'h0, 32'h7fff_ffff, 32'h8000_0000, 1'b1, 1'b1},
    '{32'h7, 32'h0, 32'h0, 32'h0, 1'b0, 1'b0},
    '{32'h0001_0000, 32'h0, 32'h0001_0000, 32'h0, 1'b0, 1'b0},
    '{32'h0, 32'hffff_0000, 32'h0, 32'h0001_0000, 1'b0, 1'b0},
    '{32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 1'b0, 1'b0},
    '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 1'b0, 1'b0},
    '{32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 1'b0, 1'b0},
    '{32'h10, 32'hffff_fff0, 32'h7fff_ffff, 32'h7fff_ffff, 1'b0, 1'b0},
    '{32'h0003_0000, 32'h0004_0000, 32'hfffe_0000, 32'h0005_8000, 1'b0, 1'b0},
    '{32'hffff_ff00, 32'h0000_0100, 32'h0, 32'h0, 1'b0, 1'b0},
    '{32'h8, 32'h8, 32'h8000_0000, 32'h7fff_ffff, 1'b0, 1'b0},
    '{32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa, 1'b0, 1'b0}
  };

  initial begin
    item_t it;
    result_t want;
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    foreach (rows[i]) begin
      it = '{rows[i].px, rows[i].py, rows[i].vx, rows[i].vy};
      if (rows[i].chk) begin
        want = '0;
        want.too_close = rows[i].tc;
        if (jacobian(it) !== want) begin
          errors++;
          $display("%0t table row %0d expected %h actual %h", $time, i, want, jacobian(it));
        end
      end
      send(it);
    end
    set_min_range(16'd0);
    send('{32'h0, 32'h0, 32'h1, 32'h1});
    send('{32'h1, 32'h0, 32'h1, 32'h1});
    set_min_range(16'hffff);
    send('{32'h0000_fffe, 32'h0, 32'h1, 32'h1});
    send('{32'h0000_ffff, 32'h0, 32'h1, 32'h1});
    send('{32'h0, 32'hffff_0000, 32'h1, 32'h1});
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: set_min_range(16'd7);
        1: set_min_range(16'($urandom()));
        2: set_min_range(16'd0);
        default: set_min_range(16'hffff);
      endcase
      if (ph == 1) no_idle = 1'b1;
      if (ph == 2) begin
        no_idle = 1'b0;
        hold_pop = 1'b1;
      end
      for (int k = 0; k < 285; k++) begin
        it = '{rand_val($urandom_range(4)), rand_val($urandom_range(4)),
               rand_val($urandom_range(4)), rand_val($urandom_range(4))};
        send(it);
        if (ph == 2 && k == 2) hold_pop = 1'b0;
      end
    end
    drain();
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
`default_nettype wire
